// ===== hw/rtl/sbalu_pkg.sv =====
`timescale 1ns / 1ps
// package for the signed byte alu: operation codes, widths and the stage record
// shared by every module of the pipeline, depends on nothing else

package sbalu_pkg;

   localparam int DATA_WIDTH = 8;
   localparam int OP_WIDTH = 2;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int DIV_BITS_PER_STAGE = 2;
   localparam int DIV_STAGES = DATA_WIDTH / DIV_BITS_PER_STAGE;

   localparam logic [OP_WIDTH-1:0] OP_ADD = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_SUB = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_MUL = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_DIV = 2'd3;

   localparam logic [DATA_WIDTH-1:0] MOST_NEGATIVE = 8'h80;
   localparam logic [DATA_WIDTH-1:0] MINUS_ONE = 8'hFF;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic [PROD_WIDTH-1:0] prod;     // product, or add/sub result in the low byte
      logic                  flag;     // add/sub overflow, or -128 / -1 on divide
      logic                  neg;      // quotient sign
      logic                  zero;     // divisor is zero
      logic [DATA_WIDTH-1:0] divisor;  // divisor magnitude
      logic [DATA_WIDTH-1:0] rem;      // partial remainder
      logic [DATA_WIDTH-1:0] work;     // dividend bits out at the top, quotient bits in
   } stage_type;

endpackage

// ===== hw/rtl/signed_byte_alu_with_overflow.sv =====
`timescale 1ns / 1ps
// Signed byte ALU: add, subtract, signed multiply and signed divide on two
// 8-bit operands, returning the low result byte and a signed overflow flag
// (also set on division by zero, which returns 0). The datapath is a six-stage
// pipeline: one set-up stage, four divider stages of two quotient bits each and
// the response register; a new request is taken every cycle while req_stall is low.
// Each stage holds while it is full and the next one stalls, so requests keep
// entering until the pipeline is full.
// Top level; depends on sbalu_pkg, sbalu_pre, sbalu_div_step and sbalu_post.

module signed_byte_alu_with_overflow (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [sbalu_pkg::OP_WIDTH-1:0]   req_type,
   input  logic [sbalu_pkg::DATA_WIDTH-1:0] req_operand_a,
   input  logic [sbalu_pkg::DATA_WIDTH-1:0] req_operand_b,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [sbalu_pkg::DATA_WIDTH-1:0] rsp_value_out,
   output logic                             rsp_overflow_flag
);
   import sbalu_pkg::*;

   logic      valid [DIV_STAGES+1];
   logic      stall [DIV_STAGES+1];
   stage_type stage [DIV_STAGES+1];

   sbalu_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_type   (req_type),
      .in_a      (req_operand_a),
      .in_b      (req_operand_b),
      .out_valid (valid[0]),
      .out_stall (stall[0]),
      .out_stage (stage[0])
   );

   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      sbalu_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid[i]),
         .in_stall  (stall[i]),
         .in_stage  (stage[i]),
         .out_valid (valid[i+1]),
         .out_stall (stall[i+1]),
         .out_stage (stage[i+1])
      );
   end

   sbalu_post u_post (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid[DIV_STAGES]),
      .in_stall  (stall[DIV_STAGES]),
      .in_stage  (stage[DIV_STAGES]),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_value (rsp_value_out),
      .out_flag  (rsp_overflow_flag)
   );

endmodule

// ===== hw/rtl/sbalu_pre.sv =====
`timescale 1ns / 1ps
// first pipeline stage: add, subtract, signed multiply and divide set-up
// depends on sbalu_pkg

module sbalu_pre (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_stall,
   input  logic [sbalu_pkg::OP_WIDTH-1:0]   in_type,
   input  logic [sbalu_pkg::DATA_WIDTH-1:0] in_a,
   input  logic [sbalu_pkg::DATA_WIDTH-1:0] in_b,
   output logic                             out_valid,
   input  logic                             out_stall,
   output sbalu_pkg::stage_type             out_stage
);
   import sbalu_pkg::*;

   logic                         valid_ff;
   stage_type                    stage_ff;
   stage_type                    stage_in;
   logic [DATA_WIDTH-1:0]        sum;
   logic [DATA_WIDTH-1:0]        diff;
   logic signed [PROD_WIDTH-1:0] product;
   logic                         sa;
   logic                         sb;

   assign sa = in_a[DATA_WIDTH-1];
   assign sb = in_b[DATA_WIDTH-1];
   assign sum = in_a + in_b;
   assign diff = in_a - in_b;
   assign product = $signed(in_a) * $signed(in_b);

   always_comb begin
      stage_in = '0;
      stage_in.op = in_type;
      stage_in.neg = sa ^ sb;
      stage_in.zero = (in_b == '0);
      stage_in.divisor = sb ? DATA_WIDTH'(-in_b) : in_b;
      stage_in.rem = '0;
      stage_in.work = sa ? DATA_WIDTH'(-in_a) : in_a;
      case (in_type)
         OP_ADD: begin
            stage_in.prod = {{DATA_WIDTH{1'b0}}, sum};
            stage_in.flag = (sa == sb) && (sum[DATA_WIDTH-1] != sa);
         end
         OP_SUB: begin
            stage_in.prod = {{DATA_WIDTH{1'b0}}, diff};
            stage_in.flag = (sa != sb) && (diff[DATA_WIDTH-1] != sa);
         end
         OP_MUL: begin
            stage_in.prod = product;
            stage_in.flag = 1'b0;
         end
         default: begin
            stage_in.prod = '0;
            stage_in.flag = (in_a == MOST_NEGATIVE) && (in_b == MINUS_ONE);
         end
      endcase
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== hw/rtl/sbalu_div_step.sv =====
`timescale 1ns / 1ps
// one divider stage: restoring division on magnitudes, two quotient bits
// per stage, other fields pass through; depends on sbalu_pkg

module sbalu_div_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  sbalu_pkg::stage_type in_stage,
   output logic                 out_valid,
   input  logic                 out_stall,
   output sbalu_pkg::stage_type out_stage
);
   import sbalu_pkg::*;

   logic                  valid_ff;
   stage_type             stage_ff;
   stage_type             stage_in;
   logic [DATA_WIDTH:0]   trial;
   logic                  fits;
   logic [DATA_WIDTH-1:0] rem;
   logic [DATA_WIDTH-1:0] work;

   always_comb begin
      rem = in_stage.rem;
      work = in_stage.work;
      trial = '0;
      fits = 1'b0;
      for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
         trial = {rem, work[DATA_WIDTH-1]};
         fits = (trial >= {1'b0, in_stage.divisor});
         rem = fits ? DATA_WIDTH'(trial - {1'b0, in_stage.divisor})
                    : trial[DATA_WIDTH-1:0];
         work = {work[DATA_WIDTH-2:0], fits};
      end
      stage_in = in_stage;
      stage_in.rem = rem;
      stage_in.work = work;
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== hw/rtl/sbalu_post.sv =====
`timescale 1ns / 1ps
// last stage: multiply overflow check, quotient sign and result select
// into the response register; depends on sbalu_pkg

module sbalu_post (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_stall,
   input  sbalu_pkg::stage_type             in_stage,
   output logic                             out_valid,
   input  logic                             out_stall,
   output logic [sbalu_pkg::DATA_WIDTH-1:0] out_value,
   output logic                             out_flag
);
   import sbalu_pkg::*;

   logic                  valid_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic                  flag_ff;
   logic [DATA_WIDTH-1:0] value_in;
   logic                  flag_in;
   logic [DATA_WIDTH:0]   prod_top;

   assign prod_top = in_stage.prod[PROD_WIDTH-1:DATA_WIDTH-1];

   always_comb begin
      case (in_stage.op)
         OP_ADD, OP_SUB: begin
            value_in = in_stage.prod[DATA_WIDTH-1:0];
            flag_in = in_stage.flag;
         end
         OP_MUL: begin
            value_in = in_stage.prod[DATA_WIDTH-1:0];
            flag_in = !((prod_top == '0) || (prod_top == '1));
         end
         default: begin
            if (in_stage.zero) begin
               value_in = '0;
               flag_in = 1'b1;
            end else begin
               value_in = in_stage.neg ? DATA_WIDTH'(-in_stage.work) : in_stage.work;
               flag_in = in_stage.flag;
            end
         end
      endcase
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         value_ff <= value_in;
         flag_ff <= flag_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;
   assign out_flag = flag_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// testbench for signed_byte_alu_with_overflow: a directed table then random requests,
// each response checked against a known row's result or an in-bench predictor of add,
// subtract, multiply and divide; depends on sbalu_pkg and signed_byte_alu_with_overflow

module tb;
   import sbalu_pkg::*;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic                  flag;
   } alu_result_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0]   op;
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      logic                  known;
      alu_result_type        result;
   } vector_type;

   localparam int RANDOM_REQUESTS = 600;
   localparam int DRAIN_CYCLES = 20;
   localparam int LIMIT_CYCLES = 200000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_WIDTH-1:0]   req_type = OP_ADD;
   logic [DATA_WIDTH-1:0] req_operand_a = '0;
   logic [DATA_WIDTH-1:0] req_operand_b = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DATA_WIDTH-1:0] rsp_value_out;
   logic                  rsp_overflow_flag;

   logic                  calm = 1'b0;
   int                    failures = 0;
   alu_result_type        expected_results[$];
   vector_type            directed_rows[$];

   signed_byte_alu_with_overflow uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_operand_a     (req_operand_a),
      .req_operand_b     (req_operand_b),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value_out     (rsp_value_out),
      .rsp_overflow_flag (rsp_overflow_flag)
   );

   always #5 clock = ~clock;

   function automatic alu_result_type predict_alu(logic [OP_WIDTH-1:0] op,
                                                  logic [DATA_WIDTH-1:0] a,
                                                  logic [DATA_WIDTH-1:0] b);
      alu_result_type               r;
      logic [DATA_WIDTH-1:0]        sum;
      logic signed [PROD_WIDTH-1:0] prod;
      logic signed [DATA_WIDTH:0]   quot;
      r = '0;
      case (op)
         OP_ADD: begin
            sum = a + b;
            r.value = sum;
            r.flag = (a[7] == b[7]) && (sum[7] != a[7]);
         end
         OP_SUB: begin
            sum = a - b;
            r.value = sum;
            r.flag = (a[7] != b[7]) && (sum[7] != a[7]);
         end
         OP_MUL: begin
            prod = $signed(a) * $signed(b);
            r.value = prod[DATA_WIDTH-1:0];
            r.flag = (prod < -128) || (prod > 127);
         end
         default: begin
            if (b == '0) begin
               r.value = '0;
               r.flag = 1'b1;
            end else begin
               quot = $signed({a[7], a}) / $signed({b[7], b});
               r.value = quot[DATA_WIDTH-1:0];
               r.flag = (a == MOST_NEGATIVE) && (b == MINUS_ONE);
            end
         end
      endcase
      return r;
   endfunction

   // extremes a quarter of the time, otherwise any byte
   function automatic logic [DATA_WIDTH-1:0] pick_operand();
      logic [DATA_WIDTH-1:0] corners[5];
      corners = '{8'h00, 8'h01, 8'h7F, MOST_NEGATIVE, MINUS_ONE};
      if ($urandom_range(3) == 0)
         return corners[$urandom_range(4)];
      return DATA_WIDTH'($urandom);
   endfunction

   task automatic send_request(vector_type row);
      while (!calm && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= row.op;
      req_operand_a <= row.a;
      req_operand_b <= row.b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (row.known)
         expected_results.push_back(row.result);
      else
         expected_results.push_back(predict_alu(row.op, row.a, row.b));
   endtask

   always @(posedge clock) begin
      alu_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected response: value_out %02h overflow_flag %0b",
                      rsp_value_out, rsp_overflow_flag);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_value_out !== want.value) begin
                  $error("value_out: expected %02h, actual %02h", want.value, rsp_value_out);
                  failures++;
               end
               if (rsp_overflow_flag !== want.flag) begin
                  $error("overflow_flag: expected %0b, actual %0b",
                         want.flag, rsp_overflow_flag);
                  failures++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 20);
      end
   end

   initial begin
      vector_type row;
      // known rows carry the typed result, the rest go through the predictor
      directed_rows.push_back({OP_ADD, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0});
      directed_rows.push_back({OP_ADD, 8'h7F, 8'h01, 1'b1, 8'h80, 1'b1});
      directed_rows.push_back({OP_ADD, 8'h80, 8'hFF, 1'b1, 8'h7F, 1'b1});
      directed_rows.push_back({OP_ADD, 8'hFF, 8'h01, 1'b1, 8'h00, 1'b0});
      directed_rows.push_back({OP_ADD, 8'h5A, 8'hA5, 1'b0, 8'h00, 1'b0});
      directed_rows.push_back({OP_SUB, 8'h80, 8'h01, 1'b1, 8'h7F, 1'b1});
      directed_rows.push_back({OP_SUB, 8'h7F, 8'hFF, 1'b1, 8'h80, 1'b1});
      directed_rows.push_back({OP_SUB, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0});
      directed_rows.push_back({OP_SUB, 8'h33, 8'hCC, 1'b0, 8'h00, 1'b0});
      directed_rows.push_back({OP_MUL, 8'h80, 8'hFF, 1'b1, 8'h80, 1'b1});
      directed_rows.push_back({OP_MUL, 8'h80, 8'h80, 1'b1, 8'h00, 1'b1});
      directed_rows.push_back({OP_MUL, 8'hFF, 8'hFF, 1'b1, 8'h01, 1'b0});
      directed_rows.push_back({OP_MUL, 8'h7F, 8'h7F, 1'b1, 8'h01, 1'b1});
      directed_rows.push_back({OP_MUL, 8'h0B, 8'hF3, 1'b0, 8'h00, 1'b0});
      directed_rows.push_back({OP_DIV, 8'h55, 8'h00, 1'b1, 8'h00, 1'b1});
      directed_rows.push_back({OP_DIV, 8'h00, 8'h00, 1'b1, 8'h00, 1'b1});
      directed_rows.push_back({OP_DIV, 8'hFF, 8'h00, 1'b1, 8'h00, 1'b1});
      directed_rows.push_back({OP_DIV, 8'h80, 8'hFF, 1'b1, 8'h80, 1'b1});
      directed_rows.push_back({OP_DIV, 8'h7F, 8'h01, 1'b1, 8'h7F, 1'b0});
      directed_rows.push_back({OP_DIV, 8'h80, 8'h01, 1'b1, 8'h80, 1'b0});
      directed_rows.push_back({OP_DIV, 8'hF9, 8'h02, 1'b0, 8'h00, 1'b0});
      directed_rows.push_back({OP_DIV, 8'h07, 8'hFE, 1'b0, 8'h00, 1'b0});
      directed_rows.push_back({OP_DIV, 8'h80, 8'h80, 1'b0, 8'h00, 1'b0});
      directed_rows.push_back({OP_DIV, 8'h7F, 8'h80, 1'b0, 8'h00, 1'b0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i]);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         calm <= (n >= 100) && (n < 250);
         if (n == 300) begin
            // hold off until the pipeline has fully drained
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_results.size() != 0)
               @(posedge clock);
         end
         row.op = OP_WIDTH'($urandom_range(3));
         row.a = pick_operand();
         row.b = pick_operand();
         row.known = 1'b0;
         row.result = '0;
         send_request(row);
      end

      req_valid <= 1'b0;
      calm <= 1'b0;
      while (expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * 10);
      $display("tb failed");
      $finish;
   end

endmodule
